// ----- rtl/blm_pkg.sv -----
// Battery level monitor: shared types, register map, fixed-point constants.
// No dependencies; imported by every module of the block.
package blm_pkg;

    localparam int unsigned ADC_W  = 10;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned VOLT_W = 20;
    localparam int unsigned COEF_W = 17;
    localparam int unsigned IVL_W  = 16;
    localparam int unsigned PROD_W = VOLT_W + COEF_W;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(TIME_W);

    // 5/1023*2.03 in Q16
    localparam logic [ADC_W-1:0]  SCALE_Q16  = ADC_W'(650);
    localparam logic [VOLT_W-1:0] NEAR_LIMIT = VOLT_W'(6553);
    localparam logic [COEF_W-1:0] GAIN_ONE   = COEF_W'(65536);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // hysteresis thresholds, Q4.16 volts
    localparam logic [VOLT_W-1:0] OK_TO_WARN_MAX    = VOLT_W'(501350);
    localparam logic [VOLT_W-1:0] WARN_TO_OK_MIN    = VOLT_W'(521012);
    localparam logic [VOLT_W-1:0] WARN_TO_DIS_BELOW = VOLT_W'(475136);
    localparam logic [VOLT_W-1:0] DIS_TO_WARN_MIN   = VOLT_W'(494797);

    // reset values of the register file
    localparam logic [COEF_W-1:0] NEAR_RST  = COEF_W'(6554);
    localparam logic [COEF_W-1:0] FAR_RST   = COEF_W'(32768);
    localparam logic [IVL_W-1:0]  IVL_RST   = IVL_W'(500);

    typedef enum logic [2:0] {
        REG_NEAR  = 3'd0,
        REG_FAR   = 3'd1,
        REG_BLINK = 3'd2,
        REG_IVL   = 3'd3,
        REG_START = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        LV_OK   = 2'd0,
        LV_WARN = 2'd1,
        LV_DIS  = 2'd2
    } t_level;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [COEF_W-1:0] near_coef;
        logic [COEF_W-1:0] far_coef;
        logic              blink_en;
        logic [IVL_W-1:0]  blink_ivl;
        logic [TIME_W-1:0] start_time;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [IVL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic q_lsb;
    } t_div_stat;

endpackage

// ----- rtl/blm_regs.sv -----
// Battery level monitor: APB-style configuration register file.
// Depends on blm_pkg.
module blm_regs
    import blm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg        r_cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_coef  <= NEAR_RST;
            r_cfg.far_coef   <= FAR_RST;
            r_cfg.blink_en   <= 1'b0;
            r_cfg.blink_ivl  <= IVL_RST;
            r_cfg.start_time <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEAR:  r_cfg.near_coef  <= pwdata[COEF_W-1:0];
                REG_FAR:   r_cfg.far_coef   <= pwdata[COEF_W-1:0];
                REG_BLINK: r_cfg.blink_en   <= pwdata[0];
                REG_IVL:   r_cfg.blink_ivl  <= pwdata[IVL_W-1:0];
                REG_START: r_cfg.start_time <= pwdata[TIME_W-1:0];
                default: ; // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEAR:  prdata = DATA_W'(r_cfg.near_coef);
            REG_FAR:   prdata = DATA_W'(r_cfg.far_coef);
            REG_BLINK: prdata = DATA_W'(r_cfg.blink_en);
            REG_IVL:   prdata = DATA_W'(r_cfg.blink_ivl);
            REG_START: prdata = DATA_W'(r_cfg.start_time);
            default:   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/blm_div.sv -----
// Battery level monitor: restoring divider, one quotient bit per cycle.
// Only the quotient LSB (blink phase parity) is kept. Depends on blm_pkg.
module blm_div
    import blm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic                r_busy;
    logic                r_done;
    logic                r_q0;
    logic [CNT_W-1:0]    r_cnt;
    logic [TIME_W-1:0]   r_dvd;
    logic [IVL_W-1:0]    r_dvs;
    logic [IVL_W-1:0]    r_rem;

    logic [IVL_W:0]      trial;
    logic [IVL_W:0]      diff;
    logic                ge;
    logic [IVL_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[TIME_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[IVL_W-1:0] : trial[IVL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TIME_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_q0  <= ge;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_stat.q_lsb = r_q0;

endmodule

// ----- rtl/battery_level_monitor_core.sv -----
// Battery level monitor top level: sequencer, two-speed smoothing filter,
// hysteresis machine and LED drive. Depends on blm_pkg, blm_regs, blm_div.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | request   | i_in_valid / o_in_ready  | i_adc_sample, i_time_ms
//  out     | result    | o_out_valid / i_out_ready| o_*_led, o_battery_usable/state,
//          |           |                          | o_filtered_voltage
//  cfg     | APB write | psel/penable/pwrite      | paddr, pwdata, prdata (pready = 1)
//
// Each request passes the sequencer states multiply, update, divide and output;
// the divide state waits for the 32-step serial divider that works out the
// blink phase, with the filter multiply and update running alongside it.
// o_in_ready is high only while the sequencer idles; one request at a time.
// The result sits in an output register, so a new request is taken while a
// result still waits; a stalled output holds the sequencer in its last step.
// Reset (synchronous, active low) clears the estimate to 0 V, the level to ok
// and loads the register defaults.
module battery_level_monitor_core
    import blm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ADC_W-1:0]  i_adc_sample,
    input  logic [TIME_W-1:0] i_time_ms,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_green_led,
    output logic              o_yellow_led,
    output logic              o_red_led,
    output logic              o_battery_usable,
    output logic [1:0]        o_battery_state,
    output logic [VOLT_W-1:0] o_filtered_voltage,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_div_req   div_req;
    t_div_stat  div_stat;

    t_state     r_state;
    t_state     n_state;

    // datapath registers
    logic [VOLT_W-1:0] r_target;
    logic [VOLT_W-1:0] r_est;
    logic [PROD_W-1:0] r_prod;
    logic              r_rising;
    t_level            r_level;

    // output register
    logic              r_out_valid;
    logic              r_green;
    logic              r_yellow;
    logic              r_red;
    logic              r_usable;
    t_level            r_st_out;
    logic [VOLT_W-1:0] r_volt_out;

    // sequencer strobes
    logic in_acc;
    logic out_free;
    logic do_mul;
    logic do_upd;
    logic do_out;

    // combinational datapath
    logic              rising;
    logic [VOLT_W-1:0] mag;
    logic [COEF_W-1:0] k_sel;
    logic [COEF_W-1:0] k;
    logic [VOLT_W-1:0] delta;
    logic [IVL_W-1:0]  ivl;
    t_level            lvl_new;
    logic              lit;

    blm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // blink phase: (time - start) / interval, interval of 0 acts as 1
    assign ivl              = (cfg.blink_ivl == '0) ? IVL_W'(1) : cfg.blink_ivl;
    assign div_req.start    = in_acc;
    assign div_req.dividend = i_time_ms - cfg.start_time;
    assign div_req.divisor  = ivl;

    blm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign in_acc   = i_in_valid & o_in_ready;
    assign out_free = ~r_out_valid | i_out_ready;

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid)    n_state = ST_MUL;
            ST_MUL:                     n_state = ST_UPD;
            ST_UPD:                     n_state = ST_DIV;
            ST_DIV:  if (div_stat.done) n_state = ST_OUT;
            ST_OUT:  if (out_free)      n_state = ST_IDLE;
            default:                    n_state = ST_IDLE;
        endcase
    end

    // ---- sequencer: strobes ----
    always_comb begin
        o_in_ready = 1'b0;
        do_mul     = 1'b0;
        do_upd     = 1'b0;
        do_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_MUL:  do_mul     = 1'b1;
            ST_UPD:  do_upd     = 1'b1;
            ST_DIV:  ;
            ST_OUT:  do_out     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- filter: step size, gain choice, clamp at unity ----
    always_comb begin
        rising = (r_target >= r_est);
        mag    = rising ? (r_target - r_est) : (r_est - r_target);
        k_sel  = (mag <= NEAR_LIMIT) ? cfg.near_coef : cfg.far_coef;
        k      = (k_sel > GAIN_ONE) ? GAIN_ONE : k_sel;
        // rounded |d|*k/2^16 never exceeds |d|, so 20 bits hold it
        delta  = r_prod[16 +: VOLT_W];
    end

    // ---- hysteresis, checks applied in order ----
    always_comb begin
        lvl_new = r_level;
        if (lvl_new == LV_OK   && r_est <= OK_TO_WARN_MAX)   lvl_new = LV_WARN;
        if (lvl_new == LV_WARN && r_est >= WARN_TO_OK_MIN)   lvl_new = LV_OK;
        if (lvl_new == LV_WARN && r_est <  WARN_TO_DIS_BELOW) lvl_new = LV_DIS;
        if (lvl_new == LV_DIS  && r_est >= DIS_TO_WARN_MIN)  lvl_new = LV_WARN;
        lit = ~cfg.blink_en | ~div_stat.q_lsb;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est   <= '0;
            r_level <= LV_OK;
        end else begin
            if (do_upd) begin
                r_est <= r_rising ? (r_est + delta) : (r_est - delta);
            end
            if (do_out) begin
                r_level <= lvl_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target <= VOLT_W'(i_adc_sample) * VOLT_W'(SCALE_Q16);
        end
        if (do_mul) begin
            r_prod   <= PROD_W'(mag) * PROD_W'(k) + ROUND_HALF;
            r_rising <= rising;
        end
        if (do_out) begin
            r_green    <= (lvl_new == LV_OK)   & lit;
            r_yellow   <= (lvl_new == LV_WARN) & lit;
            r_red      <= (lvl_new == LV_DIS)  & lit;
            r_usable   <= (lvl_new != LV_DIS);
            r_st_out   <= lvl_new;
            r_volt_out <= r_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_green_led        = r_green;
    assign o_yellow_led       = r_yellow;
    assign o_red_led          = r_red;
    assign o_battery_usable   = r_usable;
    assign o_battery_state    = r_st_out;
    assign o_filtered_voltage = r_volt_out;

endmodule

// ----- tb/tb_battery_level_monitor_core.sv -----
// Self-checking bench for battery_level_monitor_core: filter, hysteresis and LED drive.
// Depends on blm_pkg and the core; request driver and result monitor are clocked blocks.
module tb_battery_level_monitor_core;
    import blm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000; // silent cycles before the watchdog ends the run
    localparam int SETTLE_CYCLES  = 50;   // tail after the last result, above the latency
    localparam int MAX_REPORTS    = 10;
    localparam int REG_COUNT      = 5;    // REG_NEAR .. REG_START; higher indexes are spare

    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic [TIME_W-1:0] stamp;
    } t_request;

    typedef struct packed {
        logic              green;
        logic              yellow;
        logic              red;
        logic              usable;
        t_level            level;
        logic [VOLT_W-1:0] volts;
    } t_reading;

    // block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [ADC_W-1:0]  i_adc_sample = '0;
    logic [TIME_W-1:0] i_time_ms = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_green_led;
    logic              o_yellow_led;
    logic              o_red_led;
    logic              o_battery_usable;
    logic [1:0]        o_battery_state;
    logic [VOLT_W-1:0] o_filtered_voltage;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state: shadow register file, running estimate and level
    t_cfg              cfg_shadow;
    logic [VOLT_W-1:0] est_volts = '0;
    t_level            batt_level = LV_OK;

    t_request pending_requests[$];
    t_reading expected_readings[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  req_taken = 1'b0;
    int  queued_count = 0;
    int  accepted_count = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    int  settings_run = 0;
    int  level_seen[3] = '{0, 0, 0};
    logic [TIME_W-1:0] clock_ms = '0;

    battery_level_monitor_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_adc_sample       (i_adc_sample),
        .i_time_ms          (i_time_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_green_led        (o_green_led),
        .o_yellow_led       (o_yellow_led),
        .o_red_led          (o_red_led),
        .o_battery_usable   (o_battery_usable),
        .o_battery_state    (o_battery_state),
        .o_filtered_voltage (o_filtered_voltage),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the shadow model by one sample and work out the reading it should give.
    function automatic t_reading track_battery(input logic [ADC_W-1:0] adc,
                                               input logic [TIME_W-1:0] now);
        logic [VOLT_W-1:0] target;
        logic [VOLT_W-1:0] gap;
        logic              rising;
        logic [COEF_W-1:0] gain;
        logic [63:0]       delta;
        logic [IVL_W-1:0]  ivl;
        logic [TIME_W-1:0] phase;
        logic              lit;
        t_reading          r;
        target = VOLT_W'(adc) * VOLT_W'(SCALE_Q16);
        rising = (target >= est_volts);
        gap    = rising ? target - est_volts : est_volts - target;
        // near gain for steps under 0.1 V; gains above unity saturate at one
        gain = (gap <= NEAR_LIMIT) ? cfg_shadow.near_coef : cfg_shadow.far_coef;
        if (gain > GAIN_ONE) begin
            gain = GAIN_ONE;
        end
        // round half away from zero: rounding applied to the magnitude
        delta = (64'(gap) * 64'(gain) + 64'(ROUND_HALF)) >> 16;
        est_volts = rising ? est_volts + delta[VOLT_W-1:0] : est_volts - delta[VOLT_W-1:0];

        lit = 1'b1;
        if (cfg_shadow.blink_en) begin
            ivl   = (cfg_shadow.blink_ivl == '0) ? IVL_W'(1) : cfg_shadow.blink_ivl;
            phase = (now - cfg_shadow.start_time) / TIME_W'(ivl);
            lit   = ~phase[0];
        end

        // checks run in order, so ok can fall through warn to discharged in one go
        if (batt_level == LV_OK && est_volts <= OK_TO_WARN_MAX) batt_level = LV_WARN;
        if (batt_level == LV_WARN && est_volts >= WARN_TO_OK_MIN) batt_level = LV_OK;
        if (batt_level == LV_WARN && est_volts < WARN_TO_DIS_BELOW) batt_level = LV_DIS;
        if (batt_level == LV_DIS && est_volts >= DIS_TO_WARN_MIN) batt_level = LV_WARN;

        r.green  = (batt_level == LV_OK) ? lit : 1'b0;
        r.yellow = (batt_level == LV_WARN) ? lit : 1'b0;
        r.red    = (batt_level == LV_DIS) ? lit : 1'b0;
        r.usable = (batt_level != LV_DIS);
        r.level  = batt_level;
        r.volts  = est_volts;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Request driver: presents queued requests at the falling edge, holds each one
    // steady until taken, and idles at random by send_idle_pct.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            // config only changes while idle, so predicting at acceptance is exact
            expected_readings.push_back(track_battery(i_adc_sample, i_time_ms));
            accepted_count++;
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_requests.pop_front();
                i_adc_sample <= nxt.adc;
                i_time_ms    <= nxt.stamp;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Result monitor: stalls at random by stall_pct and checks every accepted result
    // against the oldest prediction, field by field.
    // ---------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("tb: result %0d %s expected %0h, got %0h",
                         results_seen, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("tb: result %0d arrived with no request outstanding",
                             results_seen);
                end
            end else begin
                want = expected_readings.pop_front();
                level_seen[want.level]++;
                compare_field("green_led", want.green, o_green_led);
                compare_field("yellow_led", want.yellow, o_yellow_led);
                compare_field("red_led", want.red, o_red_led);
                compare_field("battery_usable", want.usable, o_battery_usable);
                compare_field("battery_state", want.level, o_battery_state);
                compare_field("filtered_voltage", want.volts, o_filtered_voltage);
            end
        end
    end

    // watchdog: ends the run once nothing has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    task automatic queue_request(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] stamp);
        pending_requests.push_back('{adc: adc, stamp: stamp});
        queued_count++;
    endtask

    // all requests taken and all results back, then a short margin before config
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup then access; register is written at the edge inside access
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bits above each register's width are dropped; spare indexes do nothing
        case (idx)
            REG_NEAR:  cfg_shadow.near_coef  = data[COEF_W-1:0];
            REG_FAR:   cfg_shadow.far_coef   = data[COEF_W-1:0];
            REG_BLINK: cfg_shadow.blink_en   = data[0];
            REG_IVL:   cfg_shadow.blink_ivl  = data[IVL_W-1:0];
            REG_START: cfg_shadow.start_time = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // One setting: program every register (spare indexes too), pick the idle mix,
    // then send runs of samples that dwell around a level so the filter settles
    // and the hysteresis thresholds get crossed both ways. Halfway through, the
    // sender holds off until every result is back.
    task automatic run_phase(input logic [DATA_W-1:0] near_val, input logic [DATA_W-1:0] far_val,
                             input logic [DATA_W-1:0] blink_val, input logic [DATA_W-1:0] ivl_val,
                             input logic [DATA_W-1:0] start_val, input int send_pct,
                             input int stall_pcnt, input int n_requests);
        int dwell_adc;
        int run_left;
        int adc;
        int pick;
        write_reg(REG_NEAR, near_val);
        write_reg(REG_FAR, far_val);
        write_reg(REG_BLINK, blink_val);
        write_reg(REG_IVL, ivl_val);
        write_reg(REG_START, start_val);
        for (int i = REG_COUNT; i < (1 << (ADDR_W - 2)); i++) begin
            write_reg(3'(i), $urandom());
        end
        send_idle_pct = send_pct;
        stall_pct     = stall_pcnt;
        settings_run++;
        dwell_adc = 0;
        run_left  = 0;
        for (int n = 0; n < n_requests; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(3, 16);
                // 731, 771 and 802 codes sit on the 7.25, 7.65 and 7.95 V thresholds
                dwell_adc = ($urandom_range(0, 99) < 70) ? $urandom_range(700, 830)
                                                         : $urandom_range(0, 1023);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                adc = dwell_adc + $urandom_range(0, 6) - 3;
            end else if (pick < 85) begin
                adc = dwell_adc;
            end else begin
                adc = $urandom_range(0, 1023);
            end
            if (adc < 0) adc = 0;
            if (adc > 1023) adc = 1023;
            // timestamps mostly creep forward, with jumps and the odd arbitrary value
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                clock_ms = clock_ms + $urandom_range(0, 2000);
            end else if (pick < 90) begin
                clock_ms = clock_ms + $urandom_range(0, 200000);
            end else begin
                clock_ms = $urandom();
            end
            queue_request(ADC_W'(adc), clock_ms);
            if (n == n_requests / 2) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        cfg_shadow = '{near_coef: NEAR_RST, far_coef: FAR_RST, blink_en: 1'b0,
                       blink_ivl: IVL_RST, start_time: '0};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at reset settings, no idling
        queue_request(10'd0, 32'h0000_0000);       // ok straight to discharged in one step
        queue_request(10'd1023, 32'hFFFF_FFFF);    // full scale, far gain
        queue_request(10'd1023, 32'h0000_0001);    // discharged back to warn only
        queue_request(10'd1023, 32'hAAAA_AAAA);    // warn to ok
        queue_request(10'd1023, 32'h5555_5555);
        queue_request(10'd1023, 32'h0000_FFFF);
        queue_request(10'd1023, 32'hFFFF_0000);    // gap still over 0.1 V: far gain
        queue_request(10'd1023, 32'h8000_0000);
        queue_request(10'd1023, 32'h7FFF_FFFF);
        queue_request(10'h2AA, 32'h0000_0002);
        queue_request(10'h155, 32'h0000_0003);
        queue_request(10'd512, 32'h0000_01F4);
        queue_request(10'd1, 32'h0000_01F5);
        queue_request(10'd802, 32'h0000_03E8);
        queue_request(10'd802, 32'h0000_03E9);
        queue_request(10'd802, 32'h0000_07D0);
        queue_request(10'd771, 32'h0000_0BB8);
        queue_request(10'd771, 32'h0000_0FA0);
        queue_request(10'd760, 32'h0000_1388);
        queue_request(10'd731, 32'h0000_1770);
        queue_request(10'd731, 32'h0000_1B58);
        queue_request(10'd790, 32'h0000_1F40);
        queue_request(10'd830, 32'h0000_2328);
        queue_request(10'd1023, 32'hFFFF_FFFE);
        wait_drained();

        // settings sweep: reset values, unity and zero gains, gains above unity,
        // zero and maximum blink intervals, wrapping start times, wide data words
        run_phase(32'd6554, 32'd32768, 32'd0, 32'd500, 32'd0, 0, 0, 75);
        run_phase(32'd65536, 32'd65536, 32'd1, 32'd1, 32'hFFFF_FFF0, 50, 0, 75);
        run_phase(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 0, 50, 75);
        run_phase(32'hFFFF_FFFF, 32'h0001_0001, 32'hFFFF_FFFF, 32'h0000_FFFF, $urandom(),
                  24, 24, 75);
        run_phase($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 0, 0, 75);
        run_phase(32'd1, 32'd65535, 32'd1, 32'd3, $urandom(), 50, 0, 75);
        run_phase({15'h7FFF, 17'd3000}, $urandom_range(0, 65536), 32'hFFFF_FFFE,
                  $urandom(), $urandom(), 0, 50, 75);
        run_phase(32'd6554, 32'd32768, 32'd1, 32'd500, 32'd0, 24, 24, 75);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb: %0d samples checked over %0d register settings plus reset values",
                 results_seen, settings_run);
        $display("tb: levels seen ok %0d, warn %0d, discharged %0d; %0d mismatches",
                 level_seen[LV_OK], level_seen[LV_WARN], level_seen[LV_DIS], mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
